[design/edf_pkg.sv]
// ----------------------------------------------------------------------------
// edf_pkg
// Shared types and constants of the earliest-deadline-first task scheduler:
// command codes, task states, controller states, datapath operations and the
// control and status groups between controller and datapath.
// ----------------------------------------------------------------------------
package edf_pkg;

    // deadline and period of the idle task, never changed
    localparam logic [31:0] IDLE_DEADLINE = 32'hFFFF_FFFF;
    // reset value of the default period register
    localparam logic [31:0] DEFAULT_PERIOD_RST = 32'd5;
    // configuration port address width and register index
    localparam int PADDR_W = 3;
    localparam logic REG_DEFAULT_PERIOD = 1'b0;

    // command codes
    typedef enum logic [3:0] {
        CMD_TICK   = 4'd0,
        CMD_CREATE = 4'd1,
        CMD_YIELD  = 4'd2,
        CMD_EXIT   = 4'd3,
        CMD_SLEEP  = 4'd4,
        CMD_PYIELD = 4'd5,
        CMD_SETDL  = 4'd6,
        CMD_START  = 4'd7,
        CMD_INFO   = 4'd8
    } t_cmd;

    // task states
    typedef enum logic [1:0] {
        TS_DORMANT  = 2'd0,
        TS_READY    = 2'd1,
        TS_RUNNING  = 2'd2,
        TS_SLEEPING = 2'd3
    } t_tstate;

    // controller states
    typedef enum logic [4:0] {
        S_IDLE, S_DECODE, S_ERR, S_TICK, S_TPOST, S_PINIT, S_PICK, S_CRDY,
        S_RUN, S_FIND, S_CREATE, S_PRE, S_EXIT, S_SLEEP, S_SETDL, S_START,
        S_INFO, S_DONE
    } t_state;

    // datapath operations, one per cycle
    typedef enum logic [4:0] {
        OP_NONE, OP_LOAD, OP_ERR, OP_TICK, OP_PINIT_CUR, OP_PINIT_ZERO,
        OP_PICK, OP_CRDY, OP_RUN, OP_FIND, OP_CREATE, OP_PRE, OP_EXIT,
        OP_SLEEP, OP_SETDL, OP_START, OP_INFO, OP_DONE
    } t_op;

    typedef struct packed {
        t_op op;
    } t_ctl_cmd;

    typedef struct packed {
        logic [3:0] cmd;
        logic       kern;
        logic       cur_zero;
        logic       tid_ok;
        logic       expire;
        logic       found;
        logic       pre;
        logic       setdl_ok;
    } t_ctl_sts;

endpackage

[design/edf_task_scheduler_core.sv]
// ----------------------------------------------------------------------------
// edf_task_scheduler_core
// Earliest-deadline-first task scheduler: command channel in, one result per
// command out, APB-style register port for the default period.
// ----------------------------------------------------------------------------
// usage:
//  - a command request is taken when i_valid is high and o_stall is low;
//    o_stall stays high from the taken request until its result is loaded
//    into the output register
//  - each command gives exactly one result request on o_valid / i_stall;
//    the output register holds it while i_stall is high, and a new command
//    is taken meanwhile
//  - a tick scans the task table and may add a yield inside the scan and a
//    reschedule from the idle task after it
//  - the rate is set by the slot scans over the task table, one slot per
//    cycle; one command is worked on at a time and the next is taken in the
//    cycle after the result is loaded
//  - register 0 at byte address 0 is the default period; a write of 0 is
//    stored as 1
//  - synchronous active-low reset: all tasks dormant, idle task running
//    slot, kernel stopped, default period 5
// ----------------------------------------------------------------------------
module edf_task_scheduler_core
    import edf_pkg::*;
#(
    parameter int TASK_SLOTS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [3:0]         i_cmd,
    input  logic [4:0]         i_task_id,
    input  logic [31:0]        i_deadline_value,
    input  logic [31:0]        i_sleep_ticks,
    output logic               o_valid,
    input  logic               i_stall,
    output logic               o_status,
    output logic [4:0]         o_running_task,
    output logic               o_switched,
    output logic [4:0]         o_new_task_id,
    output logic [1:0]         o_info_state,
    output logic [31:0]        o_info_deadline,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    localparam int IW = $clog2(TASK_SLOTS + 1);

    t_ctl_cmd      ctl;
    t_ctl_sts      sts;
    logic [IW-1:0] idx;
    logic [31:0]   r_default_period;

    // default period register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_default_period <= DEFAULT_PERIOD_RST;
        end else if (psel && penable && pwrite && pready &&
                     (paddr[PADDR_W-1] == REG_DEFAULT_PERIOD)) begin
            r_default_period <= (pwdata == 32'd0) ? 32'd1 : pwdata;
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[PADDR_W-1] == REG_DEFAULT_PERIOD) ? r_default_period : 32'd0;

    edf_ctrl #(.TASK_SLOTS(TASK_SLOTS)) u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .i_sts   (sts),
        .o_ctl   (ctl),
        .o_idx   (idx)
    );

    edf_dpath #(.TASK_SLOTS(TASK_SLOTS)) u_dpath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_ctl            (ctl),
        .i_idx            (idx),
        .o_sts            (sts),
        .i_cmd            (i_cmd),
        .i_task_id        (i_task_id),
        .i_deadline_value (i_deadline_value),
        .i_sleep_ticks    (i_sleep_ticks),
        .i_default_period (r_default_period),
        .o_status         (o_status),
        .o_running_task   (o_running_task),
        .o_switched       (o_switched),
        .o_new_task_id    (o_new_task_id),
        .o_info_state     (o_info_state),
        .o_info_deadline  (o_info_deadline)
    );

`ifndef SYNTHESIS
    // a taken command keeps the block busy in the next cycle
    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("command taken but block not busy");

    // a failed command never switches tasks
    a_err_no_switch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status) |-> !o_switched)
        else $error("task switch on failed command");

    // a failed command carries no slot and no info
    a_err_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status) |->
        (o_new_task_id == 5'd0 && o_info_state == 2'd0 && o_info_deadline == 32'd0))
        else $error("failed command carries result data");
`endif

endmodule

[design/edf_dpath.sv]
// ----------------------------------------------------------------------------
// edf_dpath
// Task table, running task register, pick registers and result registers.
// Carries out one operation per cycle on the table entry chosen by the
// operation, and reports status flags to the controller.
// ----------------------------------------------------------------------------
module edf_dpath
    import edf_pkg::*;
#(
    parameter int TASK_SLOTS = 16,
    localparam int IW = $clog2(TASK_SLOTS + 1)
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  t_ctl_cmd        i_ctl,
    input  logic [IW-1:0]   i_idx,
    output t_ctl_sts        o_sts,
    input  logic [3:0]      i_cmd,
    input  logic [4:0]      i_task_id,
    input  logic [31:0]     i_deadline_value,
    input  logic [31:0]     i_sleep_ticks,
    input  logic [31:0]     i_default_period,
    output logic            o_status,
    output logic [4:0]      o_running_task,
    output logic            o_switched,
    output logic [4:0]      o_new_task_id,
    output logic [1:0]      o_info_state,
    output logic [31:0]     o_info_deadline
);

    // task table
    t_tstate       r_st  [0:TASK_SLOTS];
    logic [31:0]   r_dl  [0:TASK_SLOTS];
    logic [31:0]   r_per [0:TASK_SLOTS];
    logic [31:0]   r_sc  [0:TASK_SLOTS];

    logic [IW-1:0] r_cur, n_cur;
    logic          r_kern, n_kern;
    logic [IW-1:0] r_best, n_best;
    logic [31:0]   r_best_dl, n_best_dl;

    // latched command
    logic [3:0]    r_cmd;
    logic [4:0]    r_tid;
    logic [31:0]   r_dlv;
    logic [31:0]   r_ticks;

    // working results
    logic          r_err, n_err;
    logic [IW-1:0] r_newid, n_newid;
    logic [1:0]    r_istate, n_istate;
    logic [31:0]   r_idl, n_idl;
    logic [IW-1:0] r_before;

    // output register
    logic          r_o_status;
    logic [4:0]    r_o_running;
    logic          r_o_switched;
    logic [4:0]    r_o_newid;
    logic [1:0]    r_o_istate;
    logic [31:0]   r_o_idl;

    logic          tid_ok;
    logic [IW-1:0] tid_idx;
    logic [IW-1:0] addr;
    t_tstate       rd_st;
    logic [31:0]   rd_dl, rd_per, rd_sc;

    logic          st_we, dl_we, per_we, sc_we;
    t_tstate       st_wd;
    logic [31:0]   dl_wd, per_wd, sc_wd;
    logic [IW-1:0] st_wa;

    logic [31:0]   tk_dec, tk_dl, tk_sc, cr_d, sl_v;
    t_tstate       tk_st;
    logic          tk_exp;
    logic          better;

    assign tid_ok  = (r_tid != 5'd0) && (r_tid <= 5'(TASK_SLOTS));
    assign tid_idx = tid_ok ? r_tid[IW-1:0] : '0;

    // table address for the current operation
    always_comb begin
        unique case (i_ctl.op)
            OP_TICK, OP_PICK, OP_FIND:                 addr = i_idx;
            OP_PINIT_CUR, OP_PRE, OP_CRDY,
            OP_EXIT, OP_SLEEP:                         addr = r_cur;
            OP_RUN, OP_CREATE:                         addr = r_best;
            OP_SETDL, OP_INFO:                         addr = tid_idx;
            default:                                   addr = '0;
        endcase
    end

    assign rd_st  = r_st[addr];
    assign rd_dl  = (addr == '0) ? IDLE_DEADLINE : r_dl[addr];
    assign rd_per = r_per[addr];
    assign rd_sc  = r_sc[addr];

    // tick update of one slot
    always_comb begin
        tk_dec = rd_dl - 32'd1;
        tk_dl  = tk_dec;
        tk_st  = rd_st;
        tk_sc  = rd_sc;
        tk_exp = 1'b0;
        if (tk_dec == 32'd0) begin
            tk_dl  = rd_per;
            tk_exp = (rd_st == TS_RUNNING);
        end
        if (rd_st == TS_SLEEPING) begin
            tk_sc = rd_sc - 32'd1;
            if (tk_sc == 32'd0) begin
                tk_dl = rd_per;
                tk_st = TS_READY;
            end
        end
    end

    assign better = (rd_st == TS_READY) &&
                    ((rd_dl < r_best_dl) || ((rd_dl == r_best_dl) && (addr < r_best)));
    assign cr_d   = (r_dlv == 32'd0) ? i_default_period : r_dlv;
    assign sl_v   = (r_cmd == CMD_SLEEP) ? r_ticks : rd_dl;

    // operation decode
    always_comb begin
        st_we = 1'b0; dl_we = 1'b0; per_we = 1'b0; sc_we = 1'b0;
        st_wd = rd_st; dl_wd = rd_dl; per_wd = rd_per; sc_wd = rd_sc;
        st_wa = addr;
        n_cur = r_cur; n_kern = r_kern; n_best = r_best; n_best_dl = r_best_dl;
        n_err = r_err; n_newid = r_newid; n_istate = r_istate; n_idl = r_idl;
        o_sts.cmd      = r_cmd;
        o_sts.kern     = r_kern;
        o_sts.cur_zero = (r_cur == '0);
        o_sts.tid_ok   = tid_ok;
        o_sts.expire   = 1'b0;
        o_sts.found    = 1'b0;
        o_sts.pre      = 1'b0;
        o_sts.setdl_ok = 1'b0;
        unique case (i_ctl.op)
            OP_LOAD: begin
                n_err = 1'b0; n_newid = '0; n_istate = 2'd0; n_idl = 32'd0;
            end
            OP_ERR: n_err = 1'b1;
            OP_TICK: begin
                if (rd_st != TS_DORMANT) begin
                    st_we = 1'b1; dl_we = 1'b1; sc_we = 1'b1;
                    st_wd = tk_st; dl_wd = tk_dl; sc_wd = tk_sc;
                    o_sts.expire = tk_exp;
                end
            end
            OP_PINIT_CUR: begin
                n_best = r_cur; n_best_dl = rd_dl;
            end
            OP_PINIT_ZERO: begin
                n_best = '0; n_best_dl = IDLE_DEADLINE;
            end
            OP_PICK: begin
                if (better) begin
                    n_best = addr; n_best_dl = rd_dl;
                end
            end
            OP_CRDY: begin
                if (r_best != r_cur) begin
                    st_we = 1'b1; st_wd = TS_READY;
                end
            end
            OP_RUN: begin
                st_we = 1'b1; st_wd = TS_RUNNING; n_cur = r_best;
            end
            OP_FIND: begin
                if (rd_st == TS_DORMANT) begin
                    o_sts.found = 1'b1; n_best = addr;
                end
            end
            OP_CREATE: begin
                st_we = 1'b1; dl_we = 1'b1; per_we = 1'b1; sc_we = 1'b1;
                st_wd = TS_READY; dl_wd = cr_d; per_wd = cr_d; sc_wd = 32'd0;
                n_best_dl = cr_d; n_newid = r_best;
            end
            OP_PRE: begin
                o_sts.pre = r_kern && (r_best != r_cur) && (rd_dl > r_best_dl);
            end
            OP_EXIT: begin
                st_we = 1'b1; dl_we = 1'b1; per_we = 1'b1; sc_we = 1'b1;
                st_wd = TS_DORMANT; dl_wd = i_default_period;
                per_wd = i_default_period; sc_wd = 32'd0;
            end
            OP_SLEEP: begin
                st_we = 1'b1; sc_we = 1'b1;
                st_wd = TS_SLEEPING; sc_wd = (sl_v == 32'd0) ? 32'd1 : sl_v;
            end
            OP_SETDL: begin
                if (tid_ok && (r_dlv != 32'd0) && (rd_st == TS_READY)) begin
                    o_sts.setdl_ok = 1'b1;
                    dl_we = 1'b1; per_we = 1'b1;
                    dl_wd = r_dlv; per_wd = r_dlv;
                    n_best = tid_idx; n_best_dl = r_dlv;
                end
            end
            OP_START: n_kern = 1'b1;
            OP_INFO: begin
                if (tid_ok) begin
                    n_istate = rd_st; n_idl = rd_dl;
                end else begin
                    n_err = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    // table and control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int t = 0; t <= TASK_SLOTS; t++) begin
                r_st[t]  <= TS_DORMANT;
                r_dl[t]  <= (t == 0) ? IDLE_DEADLINE : DEFAULT_PERIOD_RST;
                r_per[t] <= (t == 0) ? IDLE_DEADLINE : DEFAULT_PERIOD_RST;
                r_sc[t]  <= 32'd0;
            end
            r_cur  <= '0;
            r_kern <= 1'b0;
        end else begin
            if (st_we)  r_st[st_wa] <= st_wd;
            if (dl_we)  r_dl[addr]  <= dl_wd;
            if (per_we) r_per[addr] <= per_wd;
            if (sc_we)  r_sc[addr]  <= sc_wd;
            r_cur  <= n_cur;
            r_kern <= n_kern;
        end
    end

    // working and result registers
    always_ff @(posedge i_clk) begin
        r_best    <= n_best;
        r_best_dl <= n_best_dl;
        r_err     <= n_err;
        r_newid   <= n_newid;
        r_istate  <= n_istate;
        r_idl     <= n_idl;
        if (i_ctl.op == OP_LOAD) begin
            r_cmd    <= i_cmd;
            r_tid    <= i_task_id;
            r_dlv    <= i_deadline_value;
            r_ticks  <= i_sleep_ticks;
            r_before <= r_cur;
        end
        if (i_ctl.op == OP_DONE) begin
            r_o_status   <= r_err;
            r_o_running  <= 5'(r_cur);
            r_o_switched <= (r_cur != r_before);
            r_o_newid    <= 5'(r_newid);
            r_o_istate   <= r_istate;
            r_o_idl      <= r_idl;
        end
    end

    assign o_status        = r_o_status;
    assign o_running_task  = r_o_running;
    assign o_switched      = r_o_switched;
    assign o_new_task_id   = r_o_newid;
    assign o_info_state    = r_o_istate;
    assign o_info_deadline = r_o_idl;

endmodule

[design/edf_ctrl.sv]
// ----------------------------------------------------------------------------
// edf_ctrl
// Command sequencer: decodes the latched command, steps the slot counters
// through table scans and issues one datapath operation per cycle. Owns the
// request handshakes on both channels.
// ----------------------------------------------------------------------------
module edf_ctrl
    import edf_pkg::*;
#(
    parameter int TASK_SLOTS = 16,
    localparam int IW = $clog2(TASK_SLOTS + 1)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    output logic          o_valid,
    input  logic          i_stall,
    input  t_ctl_sts      i_sts,
    output t_ctl_cmd      o_ctl,
    output logic [IW-1:0] o_idx
);

    localparam logic [IW-1:0] LAST = IW'(TASK_SLOTS);
    localparam logic [IW-1:0] FIRST = IW'(1);

    t_state        r_state, n_state;
    logic [IW-1:0] r_idx, n_idx;
    logic [IW-1:0] r_tidx, n_tidx;
    logic          r_yielded, n_yielded;
    logic          r_in_tick, n_in_tick;
    logic          r_base_cur, n_base_cur;
    logic          r_aft_crdy, n_aft_crdy;
    logic          r_out_valid, n_out_valid;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_idx       <= FIRST;
            r_tidx      <= FIRST;
            r_yielded   <= 1'b0;
            r_in_tick   <= 1'b0;
            r_base_cur  <= 1'b0;
            r_aft_crdy  <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_idx       <= n_idx;
            r_tidx      <= n_tidx;
            r_yielded   <= n_yielded;
            r_in_tick   <= n_in_tick;
            r_base_cur  <= n_base_cur;
            r_aft_crdy  <= n_aft_crdy;
        end
    end

    // next state and operation
    always_comb begin
        n_state = r_state; n_idx = r_idx; n_tidx = r_tidx;
        n_yielded = r_yielded; n_in_tick = r_in_tick;
        n_base_cur = r_base_cur; n_aft_crdy = r_aft_crdy;
        o_ctl.op = OP_NONE;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_ctl.op = OP_LOAD;
                    n_state  = S_DECODE;
                end
            end
            S_DECODE: begin
                n_in_tick = 1'b0;
                n_idx     = FIRST;
                unique case (i_sts.cmd)
                    CMD_TICK: begin
                        n_yielded = 1'b0;
                        n_tidx    = FIRST;
                        n_state   = i_sts.kern ? S_TICK : S_DONE;
                    end
                    CMD_CREATE: n_state = S_FIND;
                    CMD_YIELD: begin
                        n_base_cur = 1'b1;
                        n_aft_crdy = 1'b1;
                        n_state    = i_sts.kern ? S_PINIT : S_ERR;
                    end
                    CMD_EXIT:
                        n_state = (i_sts.kern && !i_sts.cur_zero) ? S_EXIT : S_ERR;
                    CMD_SLEEP, CMD_PYIELD:
                        n_state = (i_sts.kern && !i_sts.cur_zero) ? S_SLEEP : S_ERR;
                    CMD_SETDL: n_state = S_SETDL;
                    CMD_START: n_state = i_sts.kern ? S_ERR : S_START;
                    CMD_INFO:  n_state = S_INFO;
                    default:   n_state = S_ERR;
                endcase
            end
            S_ERR: begin
                o_ctl.op = OP_ERR;
                n_state  = S_DONE;
            end
            // one slot per cycle, the scan held while a yield reschedules; the first expiring running task yields
            S_TICK: begin
                o_ctl.op = OP_TICK;
                if (i_sts.expire && !r_yielded) begin
                    n_yielded  = 1'b1;
                    n_in_tick  = 1'b1;
                    n_base_cur = 1'b1;
                    n_aft_crdy = 1'b1;
                    n_state    = S_PINIT;
                end else if (r_tidx == LAST) begin
                    n_state = S_TPOST;
                end else begin
                    n_tidx = r_tidx + FIRST;
                end
            end
            // reschedule from the idle task after the scan
            S_TPOST: begin
                n_base_cur = 1'b0;
                n_aft_crdy = 1'b1;
                n_in_tick  = 1'b0;
                n_state    = i_sts.cur_zero ? S_PINIT : S_DONE;
            end
            S_PINIT: begin
                o_ctl.op = r_base_cur ? OP_PINIT_CUR : OP_PINIT_ZERO;
                n_idx    = FIRST;
                n_state  = S_PICK;
            end
            S_PICK: begin
                o_ctl.op = OP_PICK;
                if (r_idx == LAST) begin
                    n_state = r_aft_crdy ? S_CRDY : S_RUN;
                end else begin
                    n_idx = r_idx + FIRST;
                end
            end
            S_CRDY: begin
                o_ctl.op = OP_CRDY;
                n_state  = S_RUN;
            end
            S_RUN: begin
                o_ctl.op = OP_RUN;
                if (r_in_tick) begin
                    if (r_tidx == LAST) begin
                        n_state = S_TPOST;
                    end else begin
                        n_tidx  = r_tidx + FIRST;
                        n_state = S_TICK;
                    end
                end else begin
                    n_state = S_DONE;
                end
            end
            S_FIND: begin
                o_ctl.op = OP_FIND;
                if (i_sts.found) begin
                    n_state = S_CREATE;
                end else if (r_idx == LAST) begin
                    n_state = S_ERR;
                end else begin
                    n_idx = r_idx + FIRST;
                end
            end
            S_CREATE: begin
                o_ctl.op = OP_CREATE;
                n_state  = S_PRE;
            end
            S_PRE: begin
                o_ctl.op = OP_PRE;
                n_state  = i_sts.pre ? S_CRDY : S_DONE;
            end
            S_EXIT: begin
                o_ctl.op   = OP_EXIT;
                n_base_cur = 1'b0;
                n_aft_crdy = 1'b0;
                n_state    = S_PINIT;
            end
            S_SLEEP: begin
                o_ctl.op   = OP_SLEEP;
                n_base_cur = 1'b0;
                n_aft_crdy = 1'b0;
                n_state    = S_PINIT;
            end
            S_SETDL: begin
                o_ctl.op = OP_SETDL;
                n_state  = i_sts.setdl_ok ? S_PRE : S_ERR;
            end
            S_START: begin
                o_ctl.op   = OP_START;
                n_base_cur = 1'b0;
                n_aft_crdy = 1'b0;
                n_state    = S_PINIT;
            end
            S_INFO: begin
                o_ctl.op = OP_INFO;
                n_state  = S_DONE;
            end
            S_DONE: begin
                if (!(r_out_valid && i_stall)) begin
                    o_ctl.op = OP_DONE;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
        n_out_valid = (r_out_valid && i_stall) || (o_ctl.op == OP_DONE);
    end

    assign o_idx   = (r_state == S_TICK) ? r_tidx : r_idx;
    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_out_valid;

endmodule

[tb/sv/edf_task_scheduler_core_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// edf_task_scheduler_core_test
// Self-checking testbench for the EDF task scheduler core. A directed table
// covers reset contents, stopped-kernel errors, bad ids and unused commands,
// then random command mixes run under several default periods. Every result
// is checked field by field against its typed row or a model of the task table.
// ----------------------------------------------------------------------------
module edf_task_scheduler_core_test;
    import edf_pkg::*;

    localparam int SLOTS     = 16;
    localparam int DRAIN     = 3 * SLOTS + 20;
    localparam int CYCLE_CAP = 3000000;

    typedef struct packed {
        logic        status;
        logic [4:0]  running;
        logic        switched;
        logic [4:0]  new_id;
        logic [1:0]  istate;
        logic [31:0] ideadline;
    } t_sched_result;

    typedef struct {
        logic [3:0]    cmd;
        logic [4:0]    tid;
        logic [31:0]   dl;
        logic [31:0]   ticks;
        bit            typed;
        t_sched_result res;
    } t_request_row;

    logic        i_clk, i_rst_n, i_valid, o_stall, i_stall, o_valid;
    logic [3:0]  i_cmd;
    logic [4:0]  i_task_id;
    logic [31:0] i_deadline_value, i_sleep_ticks;
    logic        o_status, o_switched;
    logic [4:0]  o_running_task, o_new_task_id;
    logic [1:0]  o_info_state;
    logic [31:0] o_info_deadline;
    logic        psel, penable, pwrite, pready;
    logic [PADDR_W-1:0] paddr;
    logic [31:0] pwdata, prdata;

    edf_task_scheduler_core #(.TASK_SLOTS(SLOTS)) uut (.*);

    // model of the task table
    t_tstate     m_state [0:SLOTS];
    logic [31:0] m_dl    [0:SLOTS];
    logic [31:0] m_per   [0:SLOTS];
    logic [31:0] m_sleep [0:SLOTS];
    logic [4:0]  m_cur;
    bit          m_kern;
    logic [31:0] m_dflt;

    t_sched_result pending_results[$];
    int unsigned   mismatches, checked, cycles;
    int unsigned   cmd_count[16];
    bit            quiet;
    int            rx_hold;

    // clock and cycle limit
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP) begin
            $display("edf_task_scheduler_core regression: fail");
            $finish;
        end
    end

    function automatic int burst_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // receiver stall bursts
    always @(negedge i_clk) begin
        if (rx_hold > 0) begin
            i_stall <= 1'b1;
            rx_hold <= rx_hold - 1;
        end else begin
            i_stall <= 1'b0;
            if (!quiet && $urandom_range(0, 3) == 0) rx_hold <= burst_len();
        end
    end

    function automatic logic [4:0] edf_pick(logic [4:0] base);
        logic [4:0] best;
        best = base;
        for (int t = 1; t <= SLOTS; t++)
            if (m_state[t] == TS_READY &&
                (m_dl[t] < m_dl[best] || (m_dl[t] == m_dl[best] && t < best)))
                best = t;
        return best;
    endfunction

    function automatic void edf_run(logic [4:0] t);
        m_state[t] = TS_RUNNING;
        m_cur      = t;
    endfunction

    function automatic void edf_preempt(logic [4:0] t);
        if (m_kern && t != m_cur && m_dl[m_cur] > m_dl[t]) begin
            m_state[m_cur] = TS_READY;
            edf_run(t);
        end
    endfunction

    function automatic void edf_sleep(logic [31:0] n);
        m_state[m_cur] = TS_SLEEPING;
        m_sleep[m_cur] = (n == 0) ? 32'd1 : n;
        edf_run(edf_pick(0));
    endfunction

    // applies one command to the model and returns its result
    function automatic t_sched_result edf_apply(logic [3:0] cmd, logic [4:0] tid,
                                                logic [31:0] dl, logic [31:0] ticks);
        t_sched_result r;
        logic [4:0]    prev;
        logic [4:0]    n;
        logic [31:0]   d;
        bit            yielded;
        r    = '0;
        prev = m_cur;
        case (cmd)
            CMD_TICK: if (m_kern) begin
                yielded = 0;
                for (int t = 1; t <= SLOTS; t++) begin
                    if (m_state[t] == TS_DORMANT) continue;
                    m_dl[t] = m_dl[t] - 1;
                    if (m_dl[t] == 0) begin
                        m_dl[t] = m_per[t];
                        if (!yielded && m_state[t] == TS_RUNNING) begin
                            m_state[m_cur] = TS_READY;
                            edf_run(edf_pick(m_cur));
                            yielded = 1;
                        end
                    end
                    if (m_state[t] == TS_SLEEPING) begin
                        m_sleep[t] = m_sleep[t] - 1;
                        if (m_sleep[t] == 0) begin
                            m_dl[t]    = m_per[t];
                            m_state[t] = TS_READY;
                        end
                    end
                end
                if (m_cur == 0) begin
                    n = edf_pick(0);
                    if (n != 0) begin
                        m_state[0] = TS_READY;
                        edf_run(n);
                    end
                end
            end
            CMD_CREATE: begin
                r.status = 1;
                for (int t = 1; t <= SLOTS; t++)
                    if (m_state[t] == TS_DORMANT) begin
                        d          = (dl == 0) ? m_dflt : dl;
                        m_dl[t]    = d;
                        m_per[t]   = d;
                        m_sleep[t] = 0;
                        m_state[t] = TS_READY;
                        r.new_id   = t;
                        r.status   = 0;
                        edf_preempt(t);
                        break;
                    end
            end
            CMD_YIELD: if (!m_kern) r.status = 1;
                else begin
                    m_state[m_cur] = TS_READY;
                    edf_run(edf_pick(m_cur));
                end
            CMD_EXIT: if (!m_kern || m_cur == 0) r.status = 1;
                else begin
                    m_state[m_cur] = TS_DORMANT;
                    m_dl[m_cur]    = m_dflt;
                    m_per[m_cur]   = m_dflt;
                    m_sleep[m_cur] = 0;
                    edf_run(edf_pick(0));
                end
            CMD_SLEEP, CMD_PYIELD: if (!m_kern || m_cur == 0) r.status = 1;
                else edf_sleep(cmd == CMD_SLEEP ? ticks : m_dl[m_cur]);
            CMD_SETDL: if (dl == 0 || tid == 0 || tid > SLOTS ||
                           m_state[tid] != TS_READY) r.status = 1;
                else begin
                    m_dl[tid]  = dl;
                    m_per[tid] = dl;
                    edf_preempt(tid);
                end
            CMD_START: if (m_kern) r.status = 1;
                else begin
                    m_kern = 1;
                    edf_run(edf_pick(0));
                end
            CMD_INFO: if (tid == 0 || tid > SLOTS) r.status = 1;
                else begin
                    r.istate    = m_state[tid];
                    r.ideadline = m_dl[tid];
                end
            default: r.status = 1;
        endcase
        r.running  = m_cur;
        r.switched = (m_cur != prev);
        return r;
    endfunction

    // result checker
    always @(posedge i_clk) begin
        t_sched_result e, a;
        if (i_rst_n && o_valid && !i_stall) begin
            a = '{o_status, o_running_task, o_switched, o_new_task_id,
                  o_info_state, o_info_deadline};
            checked++;
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %p", a);
            end else begin
                e = pending_results.pop_front();
                if (e.status !== a.status || e.running !== a.running ||
                    e.switched !== a.switched || e.new_id !== a.new_id ||
                    e.istate !== a.istate || e.ideadline !== a.ideadline) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result %0d mismatch: expected %p, got %p",
                                 checked, e, a);
                end
            end
        end
    end

    // drives one request from a falling edge until it is taken
    task automatic send_request(t_request_row row);
        t_sched_result p;
        i_valid          <= 1'b1;
        i_cmd            <= row.cmd;
        i_task_id        <= row.tid;
        i_deadline_value <= row.dl;
        i_sleep_ticks    <= row.ticks;
        do @(posedge i_clk); while (o_stall);
        p = edf_apply(row.cmd, row.tid, row.dl, row.ticks);
        pending_results.push_back(row.typed ? row.res : p);
        cmd_count[row.cmd]++;
        @(negedge i_clk);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            repeat (burst_len()) @(negedge i_clk);
        end
    endtask

    task automatic settle();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (DRAIN) @(negedge i_clk);
    endtask

    task automatic write_period(logic [31:0] v);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        paddr   <= '0;
        pwdata  <= v;
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        m_dflt = (v == 0) ? 32'd1 : v;
        @(negedge i_clk);
    endtask

    function automatic logic [31:0] rand_deadline();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return $urandom_range(1, 25);
        if (r < 75) return 0;
        if (r < 90) return $urandom;
        return 32'hFFFF_FFFF - $urandom_range(0, 1);
    endfunction

    function automatic t_request_row rand_request();
        t_request_row q;
        int r;
        q       = '{default: '0};
        r       = $urandom_range(0, 99);
        q.cmd   = r < 30 ? CMD_TICK  : r < 45 ? CMD_CREATE : r < 53 ? CMD_YIELD :
                  r < 62 ? CMD_EXIT  : r < 69 ? CMD_SLEEP  : r < 74 ? CMD_PYIELD :
                  r < 85 ? CMD_SETDL : r < 87 ? CMD_START  : r < 97 ? CMD_INFO :
                  4'($urandom_range(9, 15));
        q.tid   = $urandom_range(0, 9) < 8 ? 5'($urandom_range(1, SLOTS))
                                           : 5'($urandom_range(0, 31));
        q.dl    = rand_deadline();
        r       = $urandom_range(0, 99);
        q.ticks = r < 85 ? $urandom_range(0, 8) : r < 97 ? $urandom_range(9, 60)
                                                 : $urandom;
        return q;
    endfunction

    t_request_row directed[$];

    function automatic t_request_row row(logic [3:0] c, logic [4:0] t, logic [31:0] d,
                                         logic [31:0] k, bit typed = 0,
                                         t_sched_result e = '0);
        t_request_row q;
        q = '{c, t, d, k, typed, e};
        return q;
    endfunction

    initial begin
        t_sched_result err0;
        logic [31:0]   periods[5];
        i_clk = 0; i_rst_n = 0; i_valid = 0; i_stall = 0;
        i_cmd = '0; i_task_id = '0; i_deadline_value = '0; i_sleep_ticks = '0;
        psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
        quiet = 0; rx_hold = 0; cycles = 0;

        // model reset
        for (int t = 0; t <= SLOTS; t++) begin
            m_state[t] = TS_DORMANT;
            m_dl[t]    = t == 0 ? IDLE_DEADLINE : DEFAULT_PERIOD_RST;
            m_per[t]   = m_dl[t];
            m_sleep[t] = 0;
        end
        m_cur = 0; m_kern = 0; m_dflt = DEFAULT_PERIOD_RST;

        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed table: reset contents, stopped kernel, bad ids, extremes, started kernel
        err0 = '{1'b1, 5'd0, 1'b0, 5'd0, 2'd0, 32'd0};
        directed = '{
            row(CMD_INFO, 1, 0, 0, 1, '{0, 0, 0, 0, TS_DORMANT, DEFAULT_PERIOD_RST}),
            row(CMD_YIELD, 0, 0, 0, 1, err0),
            row(CMD_EXIT, 0, 0, 0, 1, err0),
            row(CMD_SLEEP, 0, 0, 3, 1, err0),
            row(CMD_PYIELD, 0, 0, 0, 1, err0),
            row(CMD_TICK, 0, 0, 0, 1, '0),
            row(CMD_INFO, 0, 0, 0, 1, err0),
            row(CMD_INFO, 17, 0, 0, 1, err0),
            row(CMD_INFO, 31, 0, 0, 1, err0),
            row(4'd9, 0, 0, 0, 1, err0),
            row(4'd15, 31, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, err0),
            row(CMD_SETDL, 1, 0, 0, 1, err0),
            row(CMD_START, 0, 0, 0, 1, '0),
            row(CMD_START, 0, 0, 0, 1, err0),
            row(CMD_CREATE, 0, 0, 0),
            row(CMD_CREATE, 0, 32'hFFFF_FFFF, 0),
            row(CMD_CREATE, 0, 1, 0),
            row(CMD_SETDL, 2, 2, 0),
            row(CMD_INFO, 2, 0, 0),
            row(CMD_SLEEP, 0, 0, 0),
            row(CMD_TICK, 0, 0, 0),
            row(CMD_TICK, 0, 0, 0),
            row(CMD_PYIELD, 0, 0, 0),
            row(CMD_SLEEP, 0, 0, 32'hFFFF_FFFF),
            row(CMD_EXIT, 0, 0, 0),
            row(CMD_YIELD, 0, 0, 0)
        };
        foreach (directed[i]) send_request(directed[i]);
        settle();

        // random phases, each under its own default period
        periods = '{32'd1, 32'd0, 32'hFFFF_FFFF, $urandom_range(2, 12), 32'd5};
        foreach (periods[ph]) begin
            write_period(periods[ph]);
            quiet = (ph == 3);
            for (int i = 0; i < 365; i++) send_request(rand_request());
            settle();
        end

        $display("commands sent: tick %0d create %0d yield %0d exit %0d sleep %0d",
                 cmd_count[CMD_TICK], cmd_count[CMD_CREATE], cmd_count[CMD_YIELD],
                 cmd_count[CMD_EXIT], cmd_count[CMD_SLEEP]);
        $display("period yield %0d set deadline %0d info %0d; %0d results, %0d bad",
                 cmd_count[CMD_PYIELD], cmd_count[CMD_SETDL], cmd_count[CMD_INFO],
                 checked, mismatches);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("edf_task_scheduler_core regression: pass");
        else
            $display("edf_task_scheduler_core regression: fail");
        $finish;
    end

endmodule
